// ===== hw/rtl/dch_pkg.sv =====
// dch_pkg: shared types, class codes and constants for the dominant color histogram.
// No dependencies.
package dch_pkg;
   localparam int COLOR_W = 8;
   localparam int CLASS_W = 4;
   localparam int PCT_W   = 7;
   localparam int NUM_CLASSES = 9;

   localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_WHITE   = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_BLACK   = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_RED     = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_GREEN   = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_BLUE    = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_YELLOW  = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_ORANGE  = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_PURPLE  = 4'd8;
   localparam logic [CLASS_W-1:0] CLS_BROWN   = 4'd9;

   localparam logic [PCT_W-1:0] THRESHOLD_RESET = 7'd30;

   // controller -> datapath commands
   typedef struct packed {
      logic load_pixel;   // capture the pixel into the front stage
      logic hsv_start;    // launch the two quotient units
      logic classify;     // classify and count
      logic scan_start;   // begin the search over the counters
      logic scan_step;    // compare one counter
      logic pct_start;    // launch the percentage divide
      logic finish;       // result taken, clear counters
   } dch_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic div_done;
      logic scan_done;
      logic last_pixel;
   } dch_status_type;
endpackage

// ===== hw/rtl/dch_channel_if.sv =====
// dch_channel_if: generic valid/ready channel carrying a packed payload.
// Depends on nothing.
interface dch_channel_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dch_divider.sv =====
// dch_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module dch_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hw/rtl/dch_datapath.sv =====
// dch_datapath: HSV conversion, classification, class counters, dominant search.
// Depends on dch_pkg and dch_divider.
module dch_datapath #(
   parameter int CNT_W      = 21,
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dch_pkg::dch_cmd_type          cmd,
   output dch_pkg::dch_status_type       status,
   input  logic [23:0]                   pixel,
   input  logic                          pixel_last,
   input  logic [dch_pkg::PCT_W-1:0]     threshold,
   output logic [dch_pkg::CLASS_W-1:0]   result_class,
   output logic [dch_pkg::PCT_W-1:0]     result_pct
);
   import dch_pkg::*;

   localparam int IDX_W = $clog2(NUM_CLASSES + 1);
   localparam int PNUM_W = CNT_W + 7;

   // front stage
   logic [COLOR_W-1:0] r_ff, g_ff, b_ff;
   logic               last_ff;
   logic [COLOR_W-1:0] mx, mn, delta;
   logic [6:0]         v_val;
   logic [15:0]        vmul;
   logic [14:0]        smul;
   logic signed [17:0] hsum;      // 60*diff + sector offset, may be negative
   logic               hneg;
   logic [16:0]        habs;
   logic [6:0]         v_ff;
   logic               hneg_ff, hzero_ff, szero_ff;

   always_comb begin
      mx = r_ff;
      if (g_ff > mx) mx = g_ff;
      if (b_ff > mx) mx = b_ff;
      mn = r_ff;
      if (g_ff < mn) mn = g_ff;
      if (b_ff < mn) mn = b_ff;
      delta = mx - mn;
      // V = mx*100/255 via reciprocal: (x*257+...)>>16 ; exact for mx*100 <= 25500
      vmul  = 16'(mx) * 16'd100;
      v_val = 7'(({8'd0, vmul} * 24'd257 + 24'd257) >> 16);
      smul  = 15'(delta) * 15'd100;
      // blue sector reaches 300*delta, so the numerator needs 17 magnitude bits
      if (mx == r_ff)
         hsum = 18'sd60 * ($signed({10'b0, g_ff}) - $signed({10'b0, b_ff}));
      else if (mx == g_ff)
         hsum = 18'sd60 * ($signed({10'b0, b_ff}) - $signed({10'b0, r_ff}))
                + 18'sd120 * $signed({10'b0, delta});
      else
         hsum = 18'sd60 * ($signed({10'b0, r_ff}) - $signed({10'b0, g_ff}))
                + 18'sd240 * $signed({10'b0, delta});
      hneg = hsum[17];
      habs = hneg ? 17'(-hsum) : 17'(hsum);
   end

   // quotient units: saturation and hue
   logic        sdiv_done, hdiv_done;
   logic [14:0] s_quo;
   logic [16:0] h_quo;
   logic [14:0] snum_ff;
   logic [16:0] hnum_ff;
   logic [7:0]  sden_ff, hden_ff;
   logic        sdone_ff, hdone_ff;

   dch_divider #(.NUM_W(15), .DEN_W(8)) u_sdiv (
      .clock, .reset, .start(cmd.hsv_start), .numerator(snum_ff),
      .denominator(sden_ff), .done(sdiv_done), .quotient(s_quo));
   dch_divider #(.NUM_W(17), .DEN_W(8)) u_hdiv (
      .clock, .reset, .start(cmd.hsv_start), .numerator(hnum_ff),
      .denominator(hden_ff), .done(hdiv_done), .quotient(h_quo));

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         r_ff    <= pixel[23:16];
         g_ff    <= pixel[15:8];
         b_ff    <= pixel[7:0];
         last_ff <= pixel_last;
      end
      if (cmd.hsv_start) begin
         v_ff     <= v_val;
         snum_ff  <= smul;
         sden_ff  <= mx;
         hnum_ff  <= habs;
         hden_ff  <= delta;
         hneg_ff  <= hneg;
         hzero_ff <= (delta == 8'd0);
         szero_ff <= (mx == 8'd0);
      end
   end

   // divider operands are registered on hsv_start; the dividers start again on them
   // (handled by the controller issuing hsv_start twice: operands then launch)

   // done flags drop once the pixel is counted so they cannot end the percentage wait
   always_ff @(posedge clock) begin
      if (reset || cmd.hsv_start || cmd.classify) begin
         sdone_ff <= 1'b0;
         hdone_ff <= 1'b0;
      end else begin
         if (sdiv_done) sdone_ff <= 1'b1;
         if (hdiv_done) hdone_ff <= 1'b1;
      end
   end

   // classification
   logic [6:0]  s_val;
   logic [8:0]  h_val;
   logic [CLASS_W-1:0] cls;
   logic [9:0]  hq;

   always_comb begin
      s_val = szero_ff ? 7'd0 : 7'(s_quo);
      hq    = 10'(h_quo);
      if (hzero_ff)      h_val = 9'd0;
      else if (hneg_ff)  h_val = (hq == 10'd0) ? 9'd0 : 9'(10'd360 - hq);
      else               h_val = 9'(hq);
      if (v_ff < 7'd15)                        cls = CLS_BLACK;
      else if (s_val < 7'd15 && v_ff > 7'd70)  cls = CLS_WHITE;
      else if (s_val < 7'd15)                  cls = (v_ff > 7'd50) ? CLS_WHITE : CLS_BLACK;
      else if (h_val >= 9'd10 && h_val <= 9'd40 && s_val >= 7'd20 && s_val <= 7'd70
               && v_ff <= 7'd60)               cls = CLS_BROWN;
      else if (h_val <= 9'd15 || h_val >= 9'd345) cls = CLS_RED;
      else if (h_val <= 9'd40)                 cls = CLS_ORANGE;
      else if (h_val <= 9'd70)                 cls = CLS_YELLOW;
      else if (h_val <= 9'd165)                cls = CLS_GREEN;
      else if (h_val <= 9'd260)                cls = CLS_BLUE;
      else                                     cls = CLS_PURPLE;
   end

   // counters
   logic [CNT_W-1:0] counts_ff [NUM_CLASSES];
   logic [CNT_W-1:0] pix_ff;
   logic [IDX_W-1:0] scan_ff;
   logic [CNT_W-1:0] best_ff;
   logic [CLASS_W-1:0] dom_ff;
   logic             scan_done_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int i = 0; i < NUM_CLASSES; i++) counts_ff[i] <= '0;
         pix_ff <= '0;
      end else if (cmd.classify) begin
         for (int i = 0; i < NUM_CLASSES; i++)
            if (cls == CLASS_W'(i + 1) && counts_ff[i] < CNT_W'(MAX_PIXELS))
               counts_ff[i] <= counts_ff[i] + 1'b1;
         if (pix_ff < CNT_W'(MAX_PIXELS)) pix_ff <= pix_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_done_ff <= 1'b0;
         scan_ff      <= '0;
      end else if (cmd.scan_start) begin
         scan_ff      <= '0;
         scan_done_ff <= 1'b0;
         best_ff      <= '0;
         dom_ff       <= CLS_UNKNOWN;
      end else if (cmd.scan_step) begin
         if (counts_ff[scan_ff[IDX_W-1:0]] > best_ff) begin
            best_ff <= counts_ff[scan_ff[IDX_W-1:0]];
            dom_ff  <= CLASS_W'(scan_ff) + 1'b1;
         end
         scan_ff <= scan_ff + 1'b1;
         if (scan_ff == IDX_W'(NUM_CLASSES - 1)) scan_done_ff <= 1'b1;
      end
   end

   // percentage divide
   logic             pdone;
   logic [PNUM_W-1:0] pquo;
   logic [PNUM_W-1:0] pnum;
   assign pnum = PNUM_W'(best_ff) * PNUM_W'(100);

   dch_divider #(.NUM_W(PNUM_W), .DEN_W(CNT_W)) u_pdiv (
      .clock, .reset, .start(cmd.pct_start), .numerator(pnum),
      .denominator(pix_ff), .done(pdone), .quotient(pquo));

   logic [PCT_W-1:0] pct;
   assign pct          = PCT_W'(pquo);
   assign result_pct   = pct;
   assign result_class = (pct < threshold) ? CLS_UNKNOWN : dom_ff;

   assign status.div_done   = cmd.pct_start ? 1'b0 : (pdone | (sdone_ff & hdone_ff));
   assign status.scan_done  = scan_done_ff;
   assign status.last_pixel = last_ff;
endmodule

// ===== hw/rtl/dch_controller.sv =====
// dch_controller: sequencer for pixel conversion, counting and frame result.
// Depends on dch_pkg.
module dch_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dch_pkg::dch_cmd_type    cmd,
   input  dch_pkg::dch_status_type status
);
   import dch_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LATCH = 3'd1;
   localparam logic [2:0] ST_HSV   = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_PCT   = 3'd5;
   localparam logic [2:0] ST_PWAIT = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_pixel = 1'b1;
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            cmd.hsv_start = 1'b1;    // captures operands
            state_in = ST_HSV;
         end
         ST_HSV: begin
            cmd.hsv_start = 1'b1;    // launches dividers on captured operands
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.classify = 1'b1;
               if (status.last_pixel) begin
                  cmd.scan_start = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_PCT;
            else cmd.scan_step = 1'b1;
         end
         ST_PCT: begin
            cmd.pct_start = 1'b1;
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ===== hw/rtl/dominant_color_histogram_top.sv =====
// Dominant color histogram: classifies RGB888 pixels into color classes
// and, at the end of each frame, reports the most frequent class.
// Channels: req (pixel transaction: red, green, blue, last_pixel), rsp (one
// transaction per frame: dominant_class, percentage), csr (write of the
// dominance threshold, taken whenever offered).
// Each pixel passes through capture, operand latch, launch, the bit-serial
// steps of the hue quotient unit (saturation finishes earlier), the divider's
// done register and the done flag, then the class counter update.
// On the last pixel a scan over the class counters, a one-cycle launch and
// a bit-serial percentage divide follow, then the result is presented.
// The result waits on rsp while the receiver stalls; no new pixel is taken
// until the result transaction completes. The counters clear then.
// Reset (synchronous, active high) clears all counters and loads the
// threshold with 30. A threshold above 100 always reports unknown.
// Depends on dch_pkg, dch_channel_if, dch_controller, dch_datapath.
module dominant_color_histogram_top #(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic            clock,
   input  logic            reset,
   dch_channel_if.sink     req,
   dch_channel_if.source   rsp,
   dch_channel_if.sink     csr
);
   import dch_pkg::*;

   // counters hold 0..MAX_PIXELS
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);

   logic [PCT_W-1:0]   threshold_ff;
   dch_cmd_type        cmd;
   dch_status_type     status;
   logic [CLASS_W-1:0] res_class;
   logic [PCT_W-1:0]   res_pct;

   // threshold register; csr payload is the 7-bit value
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          threshold_ff <= THRESHOLD_RESET;
      else if (csr.valid) threshold_ff <= csr.payload[PCT_W-1:0];
   end

   dch_controller u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .status);

   // req payload: {red, green, blue, last_pixel}
   dch_datapath #(.CNT_W(CNT_W), .MAX_PIXELS(MAX_PIXELS)) u_dp (
      .clock, .reset, .cmd, .status,
      .pixel(req.payload[24:1]), .pixel_last(req.payload[0]),
      .threshold(threshold_ff),
      .result_class(res_class), .result_pct(res_pct));

   // rsp payload: {dominant_class, percentage}
   assign rsp.payload = {res_class, res_pct};
endmodule
